[hw/rtl/tfg_pkg.sv]
// Shared constants and widths for the T-function test vector generator.
package tfg_pkg;

  localparam int WORD_W      = 32;
  localparam int ADDR_W      = 11;
  localparam int BYTE_W      = 8;
  localparam int OUT_TDATA_W = 24;
  localparam int CFG_INDEX_W = 2;

  localparam int BLOCK_BYTES_DEFAULT = 16;

  localparam logic [WORD_W-1:0] TF_OR_CONST = 32'h0000_0005;
  localparam logic [ADDR_W-1:0] XRAM_BASE   = 11'h400;
  localparam logic [ADDR_W-1:0] KEY_OFFSET  = 11'h100;
  localparam logic [ADDR_W-1:0] PT_OFFSET   = 11'h200;
  localparam int                TOP_SHIFT   = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_KEY_ENABLE       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_PLAINTEXT_ENABLE = 2'd1;

  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_RUN  = 1'b1;

endpackage

[hw/rtl/tfg_tstep.sv]
// Shared squaring unit and adder for one T-function step.
module tfg_tstep (
  input  logic                      clk,
  input  logic                      mul_en,
  input  logic [tfg_pkg::WORD_W-1:0] word,
  output logic [tfg_pkg::WORD_W-1:0] next_word
);
  import tfg_pkg::*;

  logic [WORD_W-1:0] sq;

  always_ff @(posedge clk) begin
    if (mul_en) begin
      sq <= WORD_W'(word * word);
    end
  end

  assign next_word = word + (sq | TF_OR_CONST);

endmodule

[hw/rtl/tfunction_test_vector_generator.sv]
// Top level of the T-function test vector generator.
//
// Input stream (s_axis_*): tuser[0] selects the function, 0 loads the
// generator word from tdata[31:0], 1 runs one block. A load transaction
// yields no result. A run transaction yields BLOCK_BYTES key writes
// (0x500 up) when key_enable is set, BLOCK_BYTES plaintext writes (0x600
// up) when plaintext_enable is set, then one trigger result with tlast
// high. Each byte passes through the shared squaring unit (square, then
// add); the block is not ready for new input until the run is done.
// Configuration (cfg_*): index 0 is key_enable, 1 is plaintext_enable,
// bit 0 of cfg_data is stored; other indexes are ignored. Write only idle.
// Output stream (m_axis_*): one output register; a stalled receiver holds
// the sequencer before its next byte, nothing is lost.
// Reset clears the generator word, both enables and the output valid.
module tfunction_test_vector_generator #(
  parameter int BLOCK_BYTES = tfg_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  input  logic [tfg_pkg::WORD_W-1:0]      s_axis_tdata,  // [31:0] seed_value
  input  logic [0:0]                      s_axis_tuser,  // [0] func
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  output logic [tfg_pkg::OUT_TDATA_W-1:0] m_axis_tdata,  // [10:0] write_address, [18:11] byte_value
  output logic [0:0]                      m_axis_tuser,  // [0] is_trigger
  output logic                            m_axis_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [tfg_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic                            cfg_data
);
  import tfg_pkg::*;

  localparam int CNT_W = (BLOCK_BYTES > 1) ? $clog2(BLOCK_BYTES) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EMIT = 2'd1;
  localparam logic [1:0] ST_STEP = 2'd2;
  localparam logic [1:0] ST_TRIG = 2'd3;

  localparam logic PHASE_KEY = 1'b0;
  localparam logic PHASE_PT  = 1'b1;

  logic [1:0]        state;
  logic              phase;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] word;
  logic [WORD_W-1:0] next_word;
  logic              key_enable;
  logic              plaintext_enable;
  logic              out_free;
  logic              out_load;
  logic              mul_en;
  logic              in_xfer;
  logic [ADDR_W-1:0] addr;
  logic [BYTE_W-1:0] gen_byte;

  assign s_axis_tready = (state == ST_IDLE);
  assign cfg_ready     = 1'b1;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign out_load      = ((state == ST_EMIT) || (state == ST_TRIG)) && out_free;
  assign mul_en        = (state == ST_EMIT) && out_free;
  assign addr          = XRAM_BASE + ((phase == PHASE_KEY) ? KEY_OFFSET : PT_OFFSET)
                         + ADDR_W'(cnt);
  assign gen_byte      = word[TOP_SHIFT +: BYTE_W];

  tfg_tstep u_tstep (
    .clk       (clk),
    .mul_en    (mul_en),
    .word      (word),
    .next_word (next_word)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      key_enable       <= 1'b0;
      plaintext_enable <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_KEY_ENABLE:       key_enable       <= cfg_data;
        REG_PLAINTEXT_ENABLE: plaintext_enable <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (out_load) begin
      m_axis_tvalid <= 1'b1;
    end else if (m_axis_tvalid && m_axis_tready) begin
      m_axis_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      phase         <= PHASE_KEY;
      cnt           <= '0;
      word          <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_xfer) begin
            cnt <= '0;
            if (s_axis_tuser[0] == FUNC_LOAD) begin
              word <= s_axis_tdata;
            end else if (key_enable) begin
              phase <= PHASE_KEY;
              state <= ST_EMIT;
            end else if (plaintext_enable) begin
              phase <= PHASE_PT;
              state <= ST_EMIT;
            end else begin
              state <= ST_TRIG;
            end
          end
        end
        ST_EMIT: begin
          if (out_free) begin
            state <= ST_STEP;
          end
        end
        ST_STEP: begin
          word <= next_word;
          if (cnt == CNT_W'(BLOCK_BYTES - 1)) begin
            cnt <= '0;
            if ((phase == PHASE_KEY) && plaintext_enable) begin
              phase <= PHASE_PT;
              state <= ST_EMIT;
            end else begin
              state <= ST_TRIG;
            end
          end else begin
            cnt   <= cnt + 1'b1;
            state <= ST_EMIT;
          end
        end
        ST_TRIG: begin
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if ((state == ST_EMIT) && out_free) begin
      m_axis_tdata <= {(OUT_TDATA_W - ADDR_W - BYTE_W)'(0), gen_byte, addr};
      m_axis_tuser <= 1'b0;
      m_axis_tlast <= 1'b0;
    end else if ((state == ST_TRIG) && out_free) begin
      m_axis_tdata <= '0;
      m_axis_tuser <= 1'b1;
      m_axis_tlast <= 1'b1;
    end
  end

  a_trig_is_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser[0] == m_axis_tlast))
    else $error("trigger flag and last disagree");

  a_trig_zero_data: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser[0]) |-> (m_axis_tdata == '0))
    else $error("trigger result carries data");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_RUN)) |=> !s_axis_tready)
    else $error("ready right after a run transaction");

  a_load_idle: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready && (s_axis_tuser[0] == FUNC_LOAD)) |=> s_axis_tready)
    else $error("load transaction left block busy");

endmodule
